/* src/fsc_pkg.sv */
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared constants and control types for the smaller-count engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

   localparam int DOMAIN_SIZE_DEF = 32768;
   localparam int COUNT_BITS_DEF  = 16;
   localparam int VALUE_W         = 15;
   localparam int OUT_W           = 16;
   localparam int EPOCH_BITS      = 4;

   typedef struct packed {
      logic accept;
      logic bump_epoch;
      logic wipe_init;
      logic wipe;
      logic query;
      logic begin_update;
      logic update;
      logic finish;
   } fsc_cmd_type;

   typedef struct packed {
      logic query_done;
      logic update_done;
      logic wipe_last;
      logic epoch_full;
      logic out_free;
   } fsc_status_type;

endpackage

`default_nettype wire

/* src/fsc_if.sv */
// ----------------------------------------------------------------------------
// fsc_req_if / fsc_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [fsc_pkg::VALUE_W-1:0]  value;
   logic                                restart;

   modport source (output valid, output value, output restart, input ready);
   modport sink   (input valid, input value, input restart, output ready);
endinterface

interface fsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fsc_pkg::OUT_W-1:0]     smaller_count;

   modport source (output valid, output smaller_count, input ready);
   modport sink   (input valid, input smaller_count, output ready);
endinterface

`default_nettype wire

/* src/fsc_ram.sv */
// ----------------------------------------------------------------------------
// fsc_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/fsc_datapath.sv */
// ----------------------------------------------------------------------------
// fsc_datapath
// Tree index walker, prefix accumulator, node update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_datapath #(
   parameter int DOMAIN_SIZE = fsc_pkg::DOMAIN_SIZE_DEF,
   parameter int COUNT_BITS  = fsc_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic signed [fsc_pkg::VALUE_W-1:0]  req_value,
   input  wire fsc_pkg::fsc_cmd_type                cmd,
   output fsc_pkg::fsc_status_type                  status,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [fsc_pkg::OUT_W-1:0]                rsp_count
);

   import fsc_pkg::*;

   localparam int AW = $clog2(DOMAIN_SIZE);
   localparam int IW = AW + 2;
   localparam int PW = AW + 18;
   localparam int RW = COUNT_BITS + EPOCH_BITS;
   localparam int EW = COUNT_BITS + OUT_W;
   localparam logic signed [PW-1:0] POS_OFF = PW'(DOMAIN_SIZE / 2 + 1);
   localparam logic signed [PW-1:0] POS_MAX = PW'(DOMAIN_SIZE);
   localparam logic signed [PW-1:0] POS_MIN = PW'(1);

   logic [IW-1:0]         pos_ff, pos_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [COUNT_BITS-1:0] acc_ff, acc_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic                  rd_q_ff, rd_q_in;
   logic                  wr_pend_ff, wr_pend_in;
   logic [AW-1:0]         wa_ff, wa_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic signed [PW-1:0]  pos_raw;
   logic [IW-1:0]         low_bit;
   logic [IW-1:0]         idx_dec;
   logic                  idx_zero;
   logic                  idx_over;
   logic                  q_issue;
   logic                  u_issue;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [RW-1:0]         rd_data;
   logic [COUNT_BITS-1:0] node_cnt;
   logic [COUNT_BITS-1:0] node_inc;
   logic [COUNT_BITS:0]   sum;
   logic [EW-1:0]         acc_ext;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [RW-1:0]         wr_data;

   assign pos_raw  = {{(PW-VALUE_W){req_value[VALUE_W-1]}}, req_value} + POS_OFF;
   assign low_bit  = idx_ff & (~idx_ff + IW'(1));
   assign idx_dec  = idx_ff - IW'(1);
   assign idx_zero = (idx_ff == '0);
   assign idx_over = (idx_ff > IW'(DOMAIN_SIZE));
   assign q_issue  = cmd.query && !idx_zero;
   assign u_issue  = cmd.update && !idx_over;
   assign rd_en    = q_issue || u_issue;
   assign rd_addr  = idx_dec[AW-1:0];

   assign node_cnt = (rd_data[RW-1:COUNT_BITS] == epoch_ff) ? rd_data[COUNT_BITS-1:0] : '0;
   assign node_inc = (&node_cnt) ? node_cnt : node_cnt + COUNT_BITS'(1);
   assign sum      = {1'b0, acc_ff} + {1'b0, node_cnt};
   assign acc_ext  = EW'(acc_ff);

   assign wr_en    = cmd.wipe || wr_pend_ff;
   assign wr_addr  = cmd.wipe ? clr_addr_ff : wa_ff;
   assign wr_data  = cmd.wipe ? '0 : {epoch_ff, node_inc};

   always_comb begin
      if (pos_raw < POS_MIN) begin
         pos_in = IW'(1);
      end else if (pos_raw > POS_MAX) begin
         pos_in = IW'(DOMAIN_SIZE);
      end else begin
         pos_in = pos_raw[IW-1:0];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept) begin
         idx_in = pos_in - IW'(1);
      end else if (cmd.begin_update) begin
         idx_in = pos_ff;
      end else if (q_issue) begin
         idx_in = idx_ff - low_bit;
      end else if (u_issue) begin
         idx_in = idx_ff + low_bit;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.accept) begin
         acc_in = '0;
      end else if (rd_q_ff) begin
         acc_in = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
      end
   end

   always_comb begin
      epoch_in = epoch_ff;
      if (cmd.wipe_init) begin
         epoch_in = '0;
      end else if (cmd.bump_epoch) begin
         epoch_in = epoch_ff + EPOCH_BITS'(1);
      end
   end

   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (cmd.wipe_init) begin
         clr_addr_in = '0;
      end else if (cmd.wipe) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end
   end

   assign rd_q_in    = q_issue;
   assign wr_pend_in = u_issue;
   assign wa_in      = u_issue ? rd_addr : wa_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = (acc_ext > EW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : acc_ext[OUT_W-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff     <= '0;
         clr_addr_ff  <= '0;
         rd_q_ff      <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         epoch_ff     <= epoch_in;
         clr_addr_ff  <= clr_addr_in;
         rd_q_ff      <= rd_q_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pos_ff <= pos_in;
      end
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      wa_ff        <= wa_in;
      rsp_count_ff <= rsp_count_in;
   end

   fsc_ram #(
      .WIDTH (RW),
      .DEPTH (DOMAIN_SIZE)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.query_done  = idx_zero;
   assign status.update_done = idx_over;
   assign status.wipe_last   = (clr_addr_ff == AW'(DOMAIN_SIZE - 1));
   assign status.epoch_full  = &epoch_ff;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

   a_wipe_no_pending_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wipe && wr_pend_ff))
      else $error("clear sweep collides with a pending node write");

   a_query_and_update_apart: assert property (@(posedge clock) disable iff (reset)
      !(rd_q_ff && wr_pend_ff))
      else $error("query read and update write in flight together");

   a_finish_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   a_accept_clears_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (acc_ff == '0))
      else $error("accumulator not cleared for new request");

endmodule

`default_nettype wire

/* src/fsc_controller.sv */
// ----------------------------------------------------------------------------
// fsc_controller
// Sequencer for clear sweep, prefix query walk, update walk and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_restart,
   output logic                         req_ready,
   input  wire fsc_pkg::fsc_status_type status,
   output fsc_pkg::fsc_cmd_type         cmd
);

   import fsc_pkg::*;

   typedef enum logic [2:0] {
      S_WIPE,
      S_IDLE,
      S_WIPE_ITEM,
      S_QUERY,
      S_UPDATE,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_WIPE: begin
            cmd.wipe = 1'b1;
            if (status.wipe_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               if (req_restart && status.epoch_full) begin
                  cmd.wipe_init = 1'b1;
                  state_in      = S_WIPE_ITEM;
               end else begin
                  cmd.bump_epoch = req_restart;
                  state_in       = S_QUERY;
               end
            end
         end
         S_WIPE_ITEM: begin
            cmd.wipe = 1'b1;
            if (status.wipe_last) begin
               state_in = S_QUERY;
            end
         end
         S_QUERY: begin
            cmd.query = 1'b1;
            if (status.query_done) begin
               cmd.begin_update = 1'b1;
               state_in         = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            if (status.update_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_wrap_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (accept && req_restart && status.epoch_full) |=> (state_ff == S_WIPE_ITEM))
      else $error("epoch wrap did not start a clear sweep");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QUERY || state_ff == S_UPDATE) |-> !cmd.accept)
      else $error("request taken during a tree walk");

endmodule

`default_nettype wire

/* src/fenwick_smaller_count.sv */
// ----------------------------------------------------------------------------
// fenwick_smaller_count
// Counts earlier values strictly smaller using a binary indexed tree.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_chan (value, restart) with valid/ready; one result
//   per request leaves on rsp_chan (smaller_count) with valid/ready.
//   restart empties the tree before the request is counted and inserted.
//   Feed an array from last to first to get, per position, the number of
//   smaller elements that follow it.
// Timing:
//   A request walks the tree twice through the one tree RAM: the prefix walk
//   reads one node per set bit of pos-1, the update walk rewrites one node
//   per step on the path from pos, and the two always total
//   log2(DOMAIN_SIZE)+1 nodes. Each walk ends with one done step, then the
//   result is loaded; a new request is taken only once the result of the
//   last one has been loaded into the output register.
// Reset and clearing:
//   After reset a clear sweep writes every node with req_chan.ready low. A
//   restart switches the tree to a new epoch tag, so older nodes read as
//   zero; every 2**EPOCH_BITS-th restart runs the same sweep instead.
// Stalls:
//   A finished result waits in the output register while rsp_chan.ready is
//   low; the next request is taken meanwhile and holds before its result load.
// ----------------------------------------------------------------------------
`default_nettype none

module fenwick_smaller_count #(
   parameter int DOMAIN_SIZE = fsc_pkg::DOMAIN_SIZE_DEF,
   parameter int COUNT_BITS  = fsc_pkg::COUNT_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   fsc_req_if.sink    req_chan,
   fsc_rsp_if.source  rsp_chan
);

   import fsc_pkg::*;

   fsc_cmd_type    cmd;
   fsc_status_type status;

   fsc_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_restart (req_chan.restart),
      .req_ready   (req_chan.ready),
      .status      (status),
      .cmd         (cmd)
   );

   fsc_datapath #(
      .DOMAIN_SIZE (DOMAIN_SIZE),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_chan.value),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_count (rsp_chan.smaller_count)
   );

endmodule

`default_nettype wire

/* tb/tb_fenwick_smaller_count.sv */
// ----------------------------------------------------------------------------
// tb_fenwick_smaller_count
// Self-checking bench for the smaller-count engine. Requests are fed as
// arrays that usually open with a restart, with values drawn full range, in
// narrow windows, from the field extremes and in rising runs. A scoreboard
// keeps its own frequency tree, predicts each count at request acceptance
// and checks every result in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_fenwick_smaller_count;
   timeunit 1ns;
   timeprecision 1ps;

   import fsc_pkg::*;

   localparam int          TREE_SIZE    = DOMAIN_SIZE_DEF;
   localparam longint      NODE_LIMIT   = (64'd1 << COUNT_BITS_DEF) - 1;
   localparam longint      COUNT_LIMIT  = (64'd1 << OUT_W) - 1;
   localparam int          VALUE_MIN    = -(1 << (VALUE_W - 1));
   localparam int          VALUE_MAX    = (1 << (VALUE_W - 1)) - 1;
   localparam int          RANDOM_ITEMS = 1650;
   localparam int          MAX_GAP      = 16;
   localparam int          SETTLE       = 64;
   localparam longint      CYCLE_LIMIT  = 1500000;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_WINDOW,
      SPREAD_EDGES,
      SPREAD_RISING
   } spread_mode_type;

   class smaller_count_board;
      longint unsigned  node_count[TREE_SIZE];
      logic [OUT_W-1:0] count_queue[$];
      int               errors;

      function new();
         errors = 0;
         clear_tree();
      endfunction

      function void clear_tree();
         foreach (node_count[i]) node_count[i] = 0;
      endfunction

      function void note_request(logic signed [VALUE_W-1:0] value, logic restart);
         int              pos;
         int              idx;
         longint unsigned sum;
         if (restart) begin
            clear_tree();
         end
         pos = int'(value) + TREE_SIZE / 2 + 1;
         if (pos < 1) pos = 1;
         if (pos > TREE_SIZE) pos = TREE_SIZE;
         sum = 0;
         idx = pos - 1;
         while (idx > 0) begin
            sum += node_count[idx-1];
            if (sum > NODE_LIMIT) sum = NODE_LIMIT;
            idx -= idx & -idx;
         end
         idx = pos;
         while (idx <= TREE_SIZE) begin
            if (node_count[idx-1] < NODE_LIMIT) node_count[idx-1]++;
            idx += idx & -idx;
         end
         if (sum > COUNT_LIMIT) sum = COUNT_LIMIT;
         count_queue.insert(count_queue.size(), sum[OUT_W-1:0]);
      endfunction

      function void check_result(logic [OUT_W-1:0] got);
         logic [OUT_W-1:0] want;
         if (count_queue.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %0d", $time, got);
            errors++;
         end else begin
            want = count_queue.pop_front();
            if (got !== want) begin
               $display("%0t: smaller_count mismatch: expected %0d, actual %0d",
                        $time, want, got);
               errors++;
            end
         end
      endfunction

      function int pending();
         return count_queue.size();
      endfunction
   endclass

   logic   clock;
   logic   reset;
   logic   no_gaps;
   longint cycles;
   int     sent;

   fsc_req_if req_if ();
   fsc_rsp_if rsp_if ();

   smaller_count_board board = new();

   fenwick_smaller_count dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            board.note_request(req_if.value, req_if.restart);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_result(rsp_if.smaller_count);
         end
      end
   end

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic int clamp_value(int v);
      if (v < VALUE_MIN) return VALUE_MIN;
      if (v > VALUE_MAX) return VALUE_MAX;
      return v;
   endfunction

   // hold ready low for a drawn stall, then keep it high until a result moves
   initial begin
      int wait_cycles;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         wait_cycles = draw_gap();
         if (wait_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   task automatic send_request(input int v, input logic restart);
      int wait_cycles;
      wait_cycles = draw_gap();
      if (wait_cycles > 0) begin
         req_if.valid <= 1'b0;
         repeat (wait_cycles) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.value   <= VALUE_W'(v);
      req_if.restart <= restart;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      sent++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() > 0) @(posedge clock);
   endtask

   task automatic send_array();
      spread_mode_type mode;
      int              length;
      int              base;
      int              span;
      int              v;
      logic            restart;
      mode    = spread_mode_type'($urandom_range(0, 3));
      length  = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                             : $urandom_range(1, 60);
      base    = $urandom_range(0, 32767) + VALUE_MIN;
      span    = $urandom_range(0, 63);
      v       = base;
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < length; i++) begin
         case (mode)
            SPREAD_FULL: begin
               v = $urandom_range(0, 32767) + VALUE_MIN;
            end
            SPREAD_WINDOW: begin
               v = clamp_value(base + $urandom_range(0, span));
            end
            SPREAD_EDGES: begin
               case ($urandom_range(0, 4))
                  0: v = VALUE_MIN;
                  1: v = VALUE_MAX;
                  2: v = 0;
                  3: v = -1;
                  default: v = $urandom_range(0, 32767) + VALUE_MIN;
               endcase
            end
            default: begin
               v = clamp_value(v + $urandom_range(0, 300));
            end
         endcase
         if (i == 0) begin
            restart = ($urandom_range(0, 19) != 0);
         end else begin
            restart = ($urandom_range(0, 49) == 0);
         end
         send_request(v, restart);
      end
      if ($urandom_range(0, 9) == 0) begin
         drain_results();
      end
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      cycles         = 0;
      sent           = 0;
      no_gaps        = 1'b0;
      req_if.valid   = 1'b0;
      req_if.value   = '0;
      req_if.restart = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_request(0, 1'b1);
      send_request(VALUE_MIN, 1'b0);
      send_request(VALUE_MAX, 1'b0);
      send_request(VALUE_MIN, 1'b0);
      send_request(VALUE_MAX, 1'b0);
      send_request(-1, 1'b0);
      send_request(0, 1'b0);
      send_request(1, 1'b0);
      send_request(10922, 1'b0);
      send_request(-10923, 1'b0);
      send_request(VALUE_MAX - 1, 1'b0);
      send_request(VALUE_MIN + 1, 1'b0);
      send_request(VALUE_MAX, 1'b1);
      send_request(VALUE_MAX, 1'b0);
      send_request(VALUE_MIN, 1'b0);
      send_request(VALUE_MAX, 1'b0);
      send_request(0, 1'b1);
      send_request(0, 1'b1);
      send_request(-1, 1'b0);
      drain_results();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         send_array();
      end

      no_gaps = 1'b0;
      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
